// ===== rtl/nir_pkg.sv =====
// Package for the NEC infrared pulse decoder: phase and window class codes,
// window bounds and the result record. Used by every rtl file; no dependencies.
package nir_pkg;

    localparam int unsigned BURST_W = 17;
    localparam int unsigned CODE_W  = 32;

    // Window bounds in microseconds
    localparam logic [BURST_W-1:0] LEAD_LO   = 17'd8500;
    localparam logic [BURST_W-1:0] LEAD_HI   = 17'd9500;
    localparam logic [BURST_W-1:0] SPACE_LO  = 17'd4000;
    localparam logic [BURST_W-1:0] SPACE_HI  = 17'd5000;
    localparam logic [BURST_W-1:0] MARK_LO   = 17'd450;
    localparam logic [BURST_W-1:0] MARK_HI   = 17'd800;
    localparam logic [BURST_W-1:0] RPT_LO    = 17'd2000;
    localparam logic [BURST_W-1:0] RPT_HI    = 17'd3000;
    localparam logic [BURST_W-1:0] ONE_LO    = 17'd1000;
    localparam logic [BURST_W-1:0] GAP40_LO  = 17'd38000;
    localparam logic [BURST_W-1:0] GAP40_HI  = 17'd42000;
    localparam logic [BURST_W-1:0] GAP90_LO  = 17'd90000;
    localparam logic [BURST_W-1:0] GAP90_HI  = 17'd110000;

    typedef enum logic [2:0] {
        CL_NONE   = 3'd0,
        CL_9MS    = 3'd1,
        CL_4_5MS  = 3'd2,
        CL_562US  = 3'd3,
        CL_2_25MS = 3'd4,
        CL_1_6MS  = 3'd5,
        CL_40MS   = 3'd6,
        CL_90MS   = 3'd7
    } burst_class_t;

    typedef enum logic [6:0] {
        PH_CIDLE  = 7'b0000001,
        PH_START  = 7'b0000010,
        PH_DATA   = 7'b0000100,
        PH_DIDLE  = 7'b0001000,
        PH_ZERO   = 7'b0010000,
        PH_ONE    = 7'b0100000,
        PH_REPEAT = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic              emit;
        logic [CODE_W-1:0] code_word;
        logic              is_repeat;
    } result_t;

endpackage

// ===== rtl/nir_burst_if.sv =====
// Input channel of the pulse decoder: one burst duration per item.
// Depends on nir_pkg.
interface nir_burst_if;
    logic                           valid;
    logic                           ready;
    logic [nir_pkg::BURST_W-1:0]    burst_us;

    modport source (output valid, output burst_us, input ready);
    modport sink   (input valid, input burst_us, output ready);
endinterface

// ===== rtl/nir_code_if.sv =====
// Output channel of the pulse decoder: decoded frame or repeat marker.
// Depends on nir_pkg.
interface nir_code_if;
    logic                           valid;
    logic                           ready;
    logic [nir_pkg::CODE_W-1:0]     code_word;
    logic                           is_repeat;

    modport source (output valid, output code_word, output is_repeat, input ready);
    modport sink   (input valid, input code_word, input is_repeat, output ready);
endinterface

// ===== rtl/nir_classify.sv =====
// Sorts a burst duration into its NEC timing window.
// Depends on nir_pkg.
module nir_classify (
    input  logic [nir_pkg::BURST_W-1:0] burst_us,
    output nir_pkg::burst_class_t       cls
);

    always_comb
    begin
        if (burst_us > nir_pkg::LEAD_LO && burst_us < nir_pkg::LEAD_HI)
            cls = nir_pkg::CL_9MS;
        else if (burst_us > nir_pkg::SPACE_LO && burst_us < nir_pkg::SPACE_HI)
            cls = nir_pkg::CL_4_5MS;
        else if (burst_us >= nir_pkg::MARK_LO && burst_us <= nir_pkg::MARK_HI)
            cls = nir_pkg::CL_562US;
        else if (burst_us > nir_pkg::RPT_LO && burst_us < nir_pkg::RPT_HI)
            cls = nir_pkg::CL_2_25MS;
        else if (burst_us > nir_pkg::ONE_LO && burst_us <= nir_pkg::RPT_LO)
            cls = nir_pkg::CL_1_6MS;
        else if (burst_us > nir_pkg::GAP40_LO && burst_us < nir_pkg::GAP40_HI)
            cls = nir_pkg::CL_40MS;
        else if (burst_us > nir_pkg::GAP90_LO && burst_us < nir_pkg::GAP90_HI)
            cls = nir_pkg::CL_90MS;
        else
            cls = nir_pkg::CL_NONE;
    end

endmodule

// ===== rtl/nir_fsm.sv =====
// Frame state machine: phase, bit shifter and bit counter, one step per item.
// Depends on nir_pkg.
module nir_fsm #(
    parameter int unsigned FRAME_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  nir_pkg::burst_class_t cls,
    output nir_pkg::result_t      result
);

    localparam int unsigned CNT_W = $clog2(FRAME_BITS + 1);
    localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BITS);

    nir_pkg::phase_t             phase_reg, phase_next;
    logic [nir_pkg::CODE_W-1:0]  shift_reg, shift_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        rep;

    always_comb
    begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        rep        = 1'b0;
        result     = '0;

        if (cls == nir_pkg::CL_NONE)
        begin
            phase_next = nir_pkg::PH_CIDLE;
            shift_next = '0;
            count_next = '0;
        end
        else
        begin
            unique case (phase_reg) inside
                nir_pkg::PH_CIDLE:
                begin
                    if (cls == nir_pkg::CL_9MS)
                        phase_next = nir_pkg::PH_START;
                end
                nir_pkg::PH_START:
                begin
                    if (cls == nir_pkg::CL_4_5MS)
                        phase_next = nir_pkg::PH_DATA;
                    else if (cls == nir_pkg::CL_2_25MS)
                        phase_next = nir_pkg::PH_REPEAT;
                end
                nir_pkg::PH_DATA:
                begin
                    if (cls == nir_pkg::CL_562US)
                        phase_next = nir_pkg::PH_DIDLE;
                end
                nir_pkg::PH_DIDLE:
                begin
                    if (cls == nir_pkg::CL_562US)
                        phase_next = nir_pkg::PH_ZERO;
                    else if (cls == nir_pkg::CL_1_6MS)
                        phase_next = nir_pkg::PH_ONE;
                end
                nir_pkg::PH_ZERO, nir_pkg::PH_ONE:
                begin
                    shift_next = {shift_reg[nir_pkg::CODE_W-2:0],
                                  phase_reg == nir_pkg::PH_ONE};
                    count_next = count_reg + 1'b1;
                    if (cls == nir_pkg::CL_562US)
                        phase_next = nir_pkg::PH_DIDLE;
                end
                nir_pkg::PH_REPEAT:
                begin
                    rep = 1'b1;
                    if (cls == nir_pkg::CL_562US)
                        phase_next = nir_pkg::PH_CIDLE;
                end
                default:
                begin
                end
            endcase

            if (count_next == FRAME_CNT)
            begin
                result.emit      = 1'b1;
                result.code_word = shift_next;
                result.is_repeat = 1'b0;
                phase_next       = nir_pkg::PH_CIDLE;
                shift_next       = '0;
                count_next       = '0;
            end
            else if (rep)
            begin
                result.emit      = 1'b1;
                result.code_word = '1;
                result.is_repeat = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nir_pkg::PH_CIDLE;
            shift_reg <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
        end
    end

    a_count_below_frame: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < FRAME_CNT)
        else $error("bit count reached frame length without emitting");

    a_count_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> (phase_reg == nir_pkg::PH_DIDLE ||
                             phase_reg == nir_pkg::PH_ZERO ||
                             phase_reg == nir_pkg::PH_ONE))
        else $error("bits held outside the data phases");

    a_bad_burst_resets: assert property (@(posedge clk) disable iff (!rst_n)
        step && cls == nir_pkg::CL_NONE |=>
            phase_reg == nir_pkg::PH_CIDLE && count_reg == '0 && shift_reg == '0)
        else $error("unclassified burst did not reset the decoder");

    a_repeat_from_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        result.emit && result.is_repeat |-> phase_reg == nir_pkg::PH_REPEAT)
        else $error("repeat marker outside the repeat phase");

endmodule

// ===== rtl/nec_ir_pulse_decoder.sv =====
// Top level of the NEC infrared pulse decoder: input register, classifier,
// frame state machine and result register. Depends on nir_pkg, nir_burst_if,
// nir_code_if, nir_classify and nir_fsm.
//
//  channel  | role | payload
//  ---------+------+-------------------------------------------
//  burst    | in   | burst_us (17b, microseconds, saturated)
//  code     | out  | code_word (32b), is_repeat (1b)
//
// One item per cycle while the code channel does not stall. A burst is
// registered on accept, then classified and stepped through the state machine
// once the result register is free or drained; any result is registered. A code
// channel stall holds the result and input registers; the input stays ready while
// the result register is free or drained. Reset idles the decoder at once.
module nec_ir_pulse_decoder #(
    parameter int unsigned FRAME_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    nir_burst_if.sink      burst,
    nir_code_if.source     code
);

    logic                           in_valid_reg;
    logic [nir_pkg::BURST_W-1:0]    in_burst_reg;
    logic                           out_valid_reg;
    logic [nir_pkg::CODE_W-1:0]     out_code_reg;
    logic                           out_rep_reg;
    logic                           step;
    nir_pkg::burst_class_t          cls;
    nir_pkg::result_t               result;

    assign step        = in_valid_reg && (!out_valid_reg || code.ready);
    assign burst.ready = !in_valid_reg || step;

    nir_classify u_classify (
        .burst_us (in_burst_reg),
        .cls      (cls)
    );

    nir_fsm #(
        .FRAME_BITS (FRAME_BITS)
    ) u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cls    (cls),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (burst.ready)
                in_valid_reg <= burst.valid;
            if (step)
                out_valid_reg <= result.emit;
            else if (code.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst.valid && burst.ready)
            in_burst_reg <= burst.burst_us;
        if (step && result.emit)
        begin
            out_code_reg <= result.code_word;
            out_rep_reg  <= result.is_repeat;
        end
    end

    assign code.valid     = out_valid_reg;
    assign code.code_word = out_code_reg;
    assign code.is_repeat = out_rep_reg;

endmodule
